FILE: rtl/rope_pkg.sv
// Shared types, constants and helper functions for the rotary position embedding block.
`timescale 1ns / 1ps

package rope_pkg;

  // Default sizing
  localparam int unsigned MaxPairsDef    = 64;
  localparam int unsigned CordicItersDef = 24;
  localparam int unsigned CordicMaxIters = 32;

  // CORDIC datapath widths (Q2.30 for x and y, 2^-32 turn units for z)
  localparam int unsigned RotW = 34;

  // Inverse CORDIC gain, Q2.30
  localparam logic signed [RotW-1:0] InvGainQ30 = 34'sd652032874;
  localparam logic signed [RotW-1:0] QuarterTurn = 34'sd1073741824;
  localparam logic signed [RotW-1:0] HalfTurn    = 34'sd2147483648;

  // Operation codes of the func field
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_ROTATE = 1'b1
  } rope_func_e;

  // One input transfer
  typedef struct packed {
    logic               func;
    logic [5:0]         pair_index;
    logic [31:0]        freq_word;
    logic [23:0]        position;
    logic signed [31:0] q_first;
    logic signed [31:0] q_second;
    logic signed [31:0] k_first;
    logic signed [31:0] k_second;
    logic               k_valid;
  } rope_in_t;

  // One result transfer
  typedef struct packed {
    logic signed [31:0] q_first_out;
    logic signed [31:0] q_second_out;
    logic signed [31:0] k_first_out;
    logic signed [31:0] k_second_out;
    logic               k_out_valid;
    logic               was_rotation;
    logic               index_error;
  } rope_out_t;

  // Item context that rides along the pipeline
  typedef struct packed {
    logic               func;
    logic               err;
    logic               k_valid;
    logic signed [31:0] q_first;
    logic signed [31:0] q_second;
    logic signed [31:0] k_first;
    logic signed [31:0] k_second;
  } rope_side_t;

  // CORDIC rotation state
  typedef struct packed {
    logic signed [RotW-1:0] x;
    logic signed [RotW-1:0] y;
    logic signed [RotW-1:0] z;
    logic                   neg;
  } rope_rot_t;

  // Arctangent of 2^-i in units of 2^-32 turn, rounded
  function automatic logic [29:0] atan_turn(input int unsigned i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Round half up from Q16.16 x Q2.30 sum down to Q16.16, then saturate
  function automatic logic signed [31:0] round_sat(input logic signed [64:0] p);
    logic signed [64:0] r;
    logic signed [31:0] o;
    r = (p + 65'sd536870912) >>> 30;
    if (r > 65'sd2147483647) begin
      o = 32'sh7FFFFFFF;
    end else if (r < -65'sd2147483648) begin
      o = 32'sh80000000;
    end else begin
      o = r[31:0];
    end
    return o;
  endfunction

endpackage

FILE: rtl/rotary_position_embedding.sv
// Top level: frequency table, angle product, CORDIC cell chain and rotation products.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (rope_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (rope_out_t)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (pair_count)
//
// One item per cycle while no result is held at the output; CORDIC_ITERS is capped at 32.
// Stages: table read, angle multiply, quadrant fold, one cell per iteration,
// rotation products, round and saturate into the output register.
// A held result freezes the whole pipeline, so in_stall_o follows
// out_valid_o && out_stall_i. Reset clears valid bits and sets pair_count to 64;
// the frequency table is not cleared.
`timescale 1ns / 1ps

module rotary_position_embedding
  import rope_pkg::*;
#(
  parameter int unsigned MAX_PAIRS    = MaxPairsDef,
  parameter int unsigned CORDIC_ITERS = CordicItersDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rope_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output rope_out_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [6:0] cfg_data_i
);

  localparam int unsigned NIters = (CORDIC_ITERS > CordicMaxIters) ? CordicMaxIters
                                                                  : CORDIC_ITERS;
  localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic       en;
  logic       in_xfer;
  logic [6:0] pair_count_q;
  logic [8:0] limit;
  logic       idx_err;
  logic       ram_we;
  logic [31:0] freq_rd;

  // Pipeline advances unless a result is held at the output
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_count_q <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pair_count_q <= cfg_data_i;
    end
  end

  // Index check against the usable pair count
  assign limit   = (9'(pair_count_q) < 9'(MAX_PAIRS)) ? 9'(pair_count_q) : 9'(MAX_PAIRS);
  assign idx_err = 9'(in_data_i.pair_index) >= limit;
  assign ram_we  = in_xfer && (in_data_i.func == FUNC_LOAD) && !idx_err;

  // Frequency table
  rope_ram #(
    .WIDTH(32),
    .DEPTH(MAX_PAIRS)
  ) u_freq_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(in_data_i.pair_index)),
    .wdata_i(in_data_i.freq_word),
    .re_i   (en),
    .raddr_i(AW'(in_data_i.pair_index)),
    .rdata_o(freq_rd)
  );

  // Stage 1: item context alongside the table read
  logic       s1_valid_q;
  rope_side_t s1_side_q;
  logic [23:0] s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q.func     <= in_data_i.func;
      s1_side_q.err      <= idx_err;
      s1_side_q.k_valid  <= in_data_i.k_valid;
      s1_side_q.q_first  <= in_data_i.q_first;
      s1_side_q.q_second <= in_data_i.q_second;
      s1_side_q.k_first  <= in_data_i.k_first;
      s1_side_q.k_second <= in_data_i.k_second;
      s1_pos_q           <= in_data_i.position;
    end
  end

  // Stage 2: angle = position * frequency, modulo one turn
  logic [55:0] angle_full;
  logic        s2_valid_q;
  rope_side_t  s2_side_q;
  logic [31:0] s2_angle_q;

  assign angle_full = 56'(s1_pos_q) * 56'(freq_rd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q  <= s1_side_q;
      s2_angle_q <= angle_full[31:0];
    end
  end

  // Stage 3: fold into [-1/4, 1/4] turn, seed the cell chain
  logic signed [RotW-1:0] ang_s;
  rope_rot_t              fold_d;

  assign ang_s = RotW'($signed(s2_angle_q));

  always_comb begin
    fold_d.x   = InvGainQ30;
    fold_d.y   = '0;
    fold_d.neg = 1'b0;
    fold_d.z   = ang_s;
    if (ang_s > QuarterTurn) begin
      fold_d.z   = ang_s - HalfTurn;
      fold_d.neg = 1'b1;
    end else if (ang_s < -QuarterTurn) begin
      fold_d.z   = ang_s + HalfTurn;
      fold_d.neg = 1'b1;
    end
  end

  logic       ch_valid [NIters+1];
  rope_rot_t  ch_rot   [NIters+1];
  rope_side_t ch_side  [NIters+1];
  logic       s3_valid_q;
  rope_rot_t  s3_rot_q;
  rope_side_t s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_rot_q  <= fold_d;
      s3_side_q <= s2_side_q;
    end
  end

  assign ch_valid[0] = s3_valid_q;
  assign ch_rot[0]   = s3_rot_q;
  assign ch_side[0]  = s3_side_q;

  // CORDIC cell chain
  for (genvar i = 0; i < NIters; i++) begin : g_cell
    rope_cell #(
      .SHIFT(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(ch_valid[i]),
      .rot_i  (ch_rot[i]),
      .side_i (ch_side[i]),
      .valid_o(ch_valid[i+1]),
      .rot_o  (ch_rot[i+1]),
      .side_o (ch_side[i+1])
    );
  end

  // Stage 4: unfold and form the rotation products
  rope_rot_t              last_rot;
  rope_side_t             last_side;
  logic signed [RotW-1:0] cos_w, sin_w;
  logic signed [31:0]     cos32, sin32;
  logic                   s4_valid_q;
  rope_side_t             s4_side_q;
  logic signed [63:0]     qa_c_q, qb_s_q, qa_s_q, qb_c_q;
  logic signed [63:0]     ka_c_q, kb_s_q, ka_s_q, kb_c_q;

  assign last_rot  = ch_rot[NIters];
  assign last_side = ch_side[NIters];
  assign cos_w     = last_rot.neg ? -last_rot.x : last_rot.x;
  assign sin_w     = last_rot.neg ? -last_rot.y : last_rot.y;
  assign cos32     = cos_w[31:0];
  assign sin32     = sin_w[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= ch_valid[NIters];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_side_q <= last_side;
      qa_c_q    <= last_side.q_first  * cos32;
      qb_s_q    <= last_side.q_second * sin32;
      qa_s_q    <= last_side.q_first  * sin32;
      qb_c_q    <= last_side.q_second * cos32;
      ka_c_q    <= last_side.k_first  * cos32;
      kb_s_q    <= last_side.k_second * sin32;
      ka_s_q    <= last_side.k_first  * sin32;
      kb_c_q    <= last_side.k_second * cos32;
    end
  end

  // Stage 5: sum, round, saturate and gate into the output register
  logic      rot_ok, key_ok;
  rope_out_t out_d, out_q;
  logic      out_valid_q;

  assign rot_ok = (s4_side_q.func == FUNC_ROTATE) && !s4_side_q.err;
  assign key_ok = rot_ok && s4_side_q.k_valid;

  always_comb begin
    out_d              = '0;
    out_d.was_rotation = s4_side_q.func;
    out_d.index_error  = s4_side_q.err;
    if (rot_ok) begin
      out_d.q_first_out  = round_sat(65'(qa_c_q) - 65'(qb_s_q));
      out_d.q_second_out = round_sat(65'(qa_s_q) + 65'(qb_c_q));
    end
    if (key_ok) begin
      out_d.k_first_out  = round_sat(65'(ka_c_q) - 65'(kb_s_q));
      out_d.k_second_out = round_sat(65'(ka_s_q) + 65'(kb_c_q));
      out_d.k_out_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks; loads and index errors carry a table word that may be unwritten
  a_cos_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_valid[NIters] && (last_side.func == FUNC_ROTATE) && !last_side.err
      |-> (cos_w[RotW-1:31] == '0 || cos_w[RotW-1:31] == '1)
       && (sin_w[RotW-1:31] == '0 || sin_w[RotW-1:31] == '1))
    else $error("CORDIC output exceeds 32 bits");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.was_rotation |-> out_data_o.q_first_out == '0
      && out_data_o.q_second_out == '0 && !out_data_o.k_out_valid)
    else $error("load acknowledge carries data");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.index_error |-> out_data_o.q_first_out == '0
      && out_data_o.k_first_out == '0 && !out_data_o.k_out_valid)
    else $error("index error result carries data");

  a_key_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.k_out_valid |-> out_data_o.was_rotation
      && !out_data_o.index_error)
    else $error("key valid on a non-rotate result");

  a_we_on_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> in_valid_i && !in_stall_o && !idx_err)
    else $error("table write without a load transfer");

endmodule

FILE: rtl/rope_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rope_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rope_cell.sv
// One CORDIC rotation cell: a single micro-rotation with its own register.
`timescale 1ns / 1ps

module rope_cell
  import rope_pkg::*;
#(
  parameter int unsigned SHIFT = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  rope_rot_t  rot_i,
  input  rope_side_t side_i,
  output logic       valid_o,
  output rope_rot_t  rot_o,
  output rope_side_t side_o
);

  localparam logic signed [RotW-1:0] Atan = RotW'(atan_turn(SHIFT));

  logic       valid_q;
  rope_rot_t  rot_d, rot_q;
  rope_side_t side_q;

  // Micro-rotation toward z = 0
  always_comb begin
    rot_d.neg = rot_i.neg;
    if (rot_i.z >= 0) begin
      rot_d.x = rot_i.x - (rot_i.y >>> SHIFT);
      rot_d.y = rot_i.y + (rot_i.x >>> SHIFT);
      rot_d.z = rot_i.z - Atan;
    end else begin
      rot_d.x = rot_i.x + (rot_i.y >>> SHIFT);
      rot_d.y = rot_i.y - (rot_i.x >>> SHIFT);
      rot_d.z = rot_i.z + Atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q  <= rot_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rot_o   = rot_q;
  assign side_o  = side_q;

endmodule
